### src/assert_macros.svh
// Assertion macros shared by the pattern finder RTL.
// Depends on nothing; included by the modules that carry checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted (active low).
`define ASSERT_IMP(label, ck, rn, ante, cons, msg) \
  label: assert property (@(posedge ck) disable iff (!(rn)) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted (active low).
`define ASSERT_NXT(label, ck, rn, ante, cons, msg) \
  label: assert property (@(posedge ck) disable iff (!(rn)) (ante) |=> (cons)) \
    else $error(msg);

`endif

### src/bpf_pkg.sv
// Shared types and constants for the bit pattern finder.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package bpf_pkg;

  localparam int DATA_W    = 8;
  localparam int COUNT_W   = 4;
  localparam int PATTERN_W = 64;
  localparam int LEN_W     = 7;
  localparam int MATCH_W   = 41;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_BITS   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_LENGTH = 2'd1;

  typedef logic [MATCH_W-1:0] match_pos_t;

  typedef struct packed {
    logic       hit;
    match_pos_t pos;
  } lane_res_t;

endpackage

### src/bpf_lane.sv
// One compare lane: checks the window after a given bit of the beat.
// Depends on bpf_pkg.
`timescale 1ns / 1ps

module bpf_lane #(
  parameter int PATTERN_MAX = 64,
  parameter int SEEN_W      = 41,
  parameter int LANE_OFFSET = 1
) (
  input  logic                    lane_en_i,
  input  logic [PATTERN_MAX-1:0]  window_i,
  input  logic [PATTERN_MAX-1:0]  pattern_i,
  input  logic [PATTERN_MAX-1:0]  mask_i,
  input  logic [bpf_pkg::LEN_W-1:0] len_i,
  input  logic [SEEN_W-1:0]       seen_base_i,
  output bpf_pkg::lane_res_t      res_o
);
  import bpf_pkg::*;

  localparam int POS_W = (SEEN_W > MATCH_W) ? SEEN_W : MATCH_W;
  localparam logic [SEEN_W-1:0] SEEN_LIMIT = {1'b1, {(SEEN_W-1){1'b0}}};

  logic [SEEN_W-1:0] seen_sum;
  logic [SEEN_W-1:0] seen_k;
  logic [SEEN_W-1:0] len_ext;
  logic [SEEN_W-1:0] pos_s;
  logic [POS_W-1:0]  pos_w;
  logic              eq;

  always_comb begin
    seen_sum = seen_base_i + SEEN_W'(LANE_OFFSET);
    seen_k   = (seen_sum > SEEN_LIMIT) ? SEEN_LIMIT : seen_sum;
    len_ext  = SEEN_W'(len_i);
    eq       = (((window_i ^ pattern_i) & mask_i) == '0);
    pos_s    = seen_k - len_ext + SEEN_W'(1);
    pos_w    = POS_W'(pos_s);
    res_o.hit = lane_en_i && (len_i != '0) && (seen_k >= len_ext) && eq;
    res_o.pos = pos_w[MATCH_W-1:0];
  end

endmodule

### src/bpf_merge.sv
// Merge stage: holds one beat's lane hits and issues them lowest lane first.
// Depends on bpf_pkg and assert_macros.svh.
`timescale 1ns / 1ps

module bpf_merge #(
  parameter int LANES = 8
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           load_i,
  input  bpf_pkg::lane_res_t [LANES-1:0] lanes_i,
  output logic                           load_ready_o,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output bpf_pkg::match_pos_t            out_pos_o,
  output logic                           out_last_o
);
  import bpf_pkg::*;
  `include "assert_macros.svh"

  logic [LANES-1:0] pend_r, pend_nxt;
  match_pos_t       pos_r [LANES];
  logic             out_valid_r, out_valid_nxt;
  match_pos_t       out_pos_r, out_pos_nxt;
  logic             out_last_r, out_last_nxt;

  logic             slot_free;
  logic             issue;
  logic [LANES-1:0] sel_oh;
  logic [LANES-1:0] pend_after;
  logic             found;
  match_pos_t       sel_pos;

  always_comb begin
    sel_oh  = '0;
    found   = 1'b0;
    sel_pos = '0;
    for (int i = 0; i < LANES; i++) begin
      if (pend_r[i] && !found) begin
        sel_oh[i] = 1'b1;
        found     = 1'b1;
      end
    end
    for (int i = 0; i < LANES; i++) begin
      sel_pos = sel_pos | (sel_oh[i] ? pos_r[i] : '0);
    end
    pend_after   = pend_r & ~sel_oh;
    slot_free    = !out_valid_r || out_ready_i;
    issue        = (pend_r != '0) && slot_free;
    load_ready_o = (pend_r == '0) || (issue && (pend_after == '0));
  end

  always_comb begin
    pend_nxt      = pend_r;
    out_valid_nxt = out_valid_r;
    out_pos_nxt   = out_pos_r;
    out_last_nxt  = out_last_r;
    if (issue) begin
      pend_nxt = pend_after;
    end
    if (load_i) begin
      for (int i = 0; i < LANES; i++) begin
        pend_nxt[i] = lanes_i[i].hit;
      end
    end
    if (issue) begin
      out_valid_nxt = 1'b1;
      out_pos_nxt   = sel_pos;
      out_last_nxt  = (pend_after == '0);
    end else if (out_ready_i) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_pos_r  <= out_pos_nxt;
    out_last_r <= out_last_nxt;
    if (load_i) begin
      for (int i = 0; i < LANES; i++) begin
        pos_r[i] <= lanes_i[i].pos;
      end
    end
  end

  assign out_valid_o = out_valid_r;
  assign out_pos_o   = out_pos_r;
  assign out_last_o  = out_last_r;

  `ASSERT_IMP(a_more_pending, clk, rst_n, out_valid_r && !out_last_r, pend_r != '0,
    "non-last result shown with nothing pending")
  `ASSERT_NXT(a_issue_lands, clk, rst_n, (pend_r != '0) && slot_free, out_valid_r,
    "pending hit not moved to output register")
  `ASSERT_IMP(a_load_when_ready, clk, rst_n, load_i, load_ready_o,
    "merge loaded while still holding hits")

endmodule

### src/bit_pattern_finder.sv
// Bit pattern finder: stream state, per-bit compare lanes and merge stage.
// Depends on bpf_pkg, bpf_lane, bpf_merge and assert_macros.svh.
//
// Usage:
//   cfg channel: write pattern_bits (index CFG_PATTERN_BITS) and
//   pattern_length (index CFG_PATTERN_LENGTH) while the block is idle;
//   cfg_ready is always high and other indexes are dropped.
//   in channel: each beat carries up to BITS_PER_ITEM stream bits, first
//   bit in data bit 7; stream_start clears window and position first.
//   out channel: one beat per match, 1-based start position in stream
//   order, last_match set on the final match of an input beat.
// Timing: hits are registered in the merge buffer, then in the output register;
//   further matches follow one per cycle while out_ready stays high.
// Throughput: one input beat per cycle while out_ready is high and each beat
//   yields at most one match; a beat with more holds the single merge buffer.
// Reset: clears the config registers, window, position count and pending hits.
// Stall: when out_ready is low the output register holds its beat, the
//   merge buffer fills and in_ready drops until it drains.
`timescale 1ns / 1ps

module bit_pattern_finder #(
  parameter int PATTERN_MAX   = 64,
  parameter int POSITION_BITS = 40,
  parameter int BITS_PER_ITEM = 8
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [bpf_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [bpf_pkg::PATTERN_W-1:0] cfg_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [bpf_pkg::DATA_W-1:0]    in_data_bits,
  input  logic [bpf_pkg::COUNT_W-1:0]   in_bit_count,
  input  logic                          in_stream_start,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [bpf_pkg::MATCH_W-1:0]   out_match_position,
  output logic                          out_last_match
);
  import bpf_pkg::*;
  `include "assert_macros.svh"

  localparam int SEEN_W = POSITION_BITS + 1;
  localparam int EXT_W  = PATTERN_MAX + DATA_W;
  localparam logic [SEEN_W-1:0] SEEN_LIMIT = {1'b1, {(SEEN_W-1){1'b0}}};

  logic [PATTERN_W-1:0]   pattern_bits_r;
  logic [LEN_W-1:0]       pattern_length_r;
  logic [PATTERN_MAX-1:0] window_r, window_nxt;
  logic [SEEN_W-1:0]      seen_r, seen_nxt;

  logic [PATTERN_MAX-1:0] win_base;
  logic [SEEN_W-1:0]      seen_base;
  logic [COUNT_W-1:0]     cnt;
  logic [COUNT_W-1:0]     shamt;
  logic [EXT_W-1:0]       ext;
  logic [EXT_W-1:0]       ext_sh;
  logic [SEEN_W-1:0]      seen_sum;
  logic [LEN_W-1:0]       len_eff;
  logic [PATTERN_MAX-1:0] mask;
  logic [PATTERN_MAX-1:0] pattern_use;
  logic                   in_fire;
  logic                   any_hit;

  lane_res_t [BITS_PER_ITEM-1:0] lane_res;

  assign cfg_ready = 1'b1;
  assign in_fire   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pattern_bits_r   <= '0;
      pattern_length_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_PATTERN_BITS:   pattern_bits_r   <= cfg_data;
        CFG_PATTERN_LENGTH: pattern_length_r <= cfg_data[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    len_eff = (pattern_length_r > LEN_W'(PATTERN_MAX)) ? LEN_W'(PATTERN_MAX)
                                                        : pattern_length_r;
    for (int i = 0; i < PATTERN_MAX; i++) begin
      mask[i] = (LEN_W'(i) < len_eff);
    end
    pattern_use = pattern_bits_r[PATTERN_MAX-1:0];
  end

  always_comb begin
    win_base  = in_stream_start ? '0 : window_r;
    seen_base = in_stream_start ? '0 : seen_r;
    cnt       = (in_bit_count > COUNT_W'(BITS_PER_ITEM)) ? COUNT_W'(BITS_PER_ITEM)
                                                          : in_bit_count;
    ext       = {win_base, in_data_bits};
    shamt     = COUNT_W'(DATA_W) - cnt;
    ext_sh    = ext >> shamt;
    seen_sum  = seen_base + SEEN_W'(cnt);
    window_nxt = in_fire ? ext_sh[PATTERN_MAX-1:0] : window_r;
    seen_nxt   = in_fire ? ((seen_sum > SEEN_LIMIT) ? SEEN_LIMIT : seen_sum) : seen_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_r <= '0;
      seen_r   <= '0;
    end else begin
      window_r <= window_nxt;
      seen_r   <= seen_nxt;
    end
  end

  for (genvar k = 0; k < BITS_PER_ITEM; k++) begin : g_lane
    logic [EXT_W-1:0] ext_k;
    assign ext_k = ext >> (DATA_W - 1 - k);

    bpf_lane #(
      .PATTERN_MAX (PATTERN_MAX),
      .SEEN_W      (SEEN_W),
      .LANE_OFFSET (k + 1)
    ) u_lane (
      .lane_en_i   (COUNT_W'(k) < cnt),
      .window_i    (ext_k[PATTERN_MAX-1:0]),
      .pattern_i   (pattern_use),
      .mask_i      (mask),
      .len_i       (len_eff),
      .seen_base_i (seen_base),
      .res_o       (lane_res[k])
    );
  end

  always_comb begin
    any_hit = 1'b0;
    for (int i = 0; i < BITS_PER_ITEM; i++) begin
      any_hit = any_hit | lane_res[i].hit;
    end
  end

  bpf_merge #(
    .LANES (BITS_PER_ITEM)
  ) u_merge (
    .clk          (clk),
    .rst_n        (rst_n),
    .load_i       (in_fire && any_hit),
    .lanes_i      (lane_res),
    .load_ready_o (in_ready),
    .out_valid_o  (out_valid),
    .out_ready_i  (out_ready),
    .out_pos_o    (out_match_position),
    .out_last_o   (out_last_match)
  );

  `ASSERT_IMP(a_seen_sat, clk, rst_n, 1'b1, seen_r <= SEEN_LIMIT,
    "position count above saturation limit")
  `ASSERT_NXT(a_start_clears, clk, rst_n, in_fire && in_stream_start,
    seen_r <= SEEN_W'(BITS_PER_ITEM), "stream start did not restart position count")

endmodule

### tb/sv/bit_pattern_finder_tb.sv
// Testbench for bit_pattern_finder: directed and random bit streams under changing patterns.
// Depends on bpf_pkg and the bit_pattern_finder RTL; a scoreboard class predicts every match.
`timescale 1ns / 1ps

module bit_pattern_finder_tb;
  import bpf_pkg::*;

  localparam int PATTERN_MAX    = 64;
  localparam int POSITION_BITS  = 40;
  localparam int BITS_PER_ITEM  = 8;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int SETTLE_CYCLES  = 20;
  localparam int HOLD_CYCLES    = 300;
  localparam int PHASE_BEATS    = 38;
  localparam int MAX_REPORTS    = 10;

  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 2'd3;
  localparam logic [MATCH_W-1:0] SEEN_LIMIT = MATCH_W'(1) << POSITION_BITS;

  typedef struct {
    match_pos_t pos;
    logic       last;
  } match_t;

  class match_scoreboard;
    logic [PATTERN_W-1:0] pattern;
    logic [LEN_W-1:0]     pat_len;
    logic [PATTERN_W-1:0] window;
    logic [MATCH_W-1:0]   seen;
    match_t               pending[$];
    int                   errors;

    function new();
      pattern = '0;
      pat_len = '0;
      window  = '0;
      seen    = '0;
      errors  = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [PATTERN_W-1:0] value);
      case (idx)
        CFG_PATTERN_BITS: begin
          pattern = value;
        end
        CFG_PATTERN_LENGTH: begin
          pat_len = value[LEN_W-1:0];
        end
        default: begin
        end
      endcase
    endfunction

    function int active_len();
      return (pat_len > PATTERN_MAX) ? PATTERN_MAX : int'(pat_len);
    endfunction

    function void take_beat(logic [DATA_W-1:0] d, logic [COUNT_W-1:0] c, logic s);
      int                   nbits;
      int                   len;
      int                   hits;
      int                   k;
      logic [PATTERN_W-1:0] mask;
      match_t               m;
      hits = 0;
      if (s) begin
        window = '0;
        seen   = '0;
      end
      nbits = (c > BITS_PER_ITEM) ? BITS_PER_ITEM : int'(c);
      len   = active_len();
      mask  = (len >= PATTERN_W) ? '1 : ((PATTERN_W'(1) << len) - PATTERN_W'(1));
      for (k = 0; k < nbits; k++) begin
        window = {window[PATTERN_W-2:0], d[DATA_W-1-k]};
        if (seen < SEEN_LIMIT) seen = seen + MATCH_W'(1);
        if (len != 0 && seen >= MATCH_W'(len) && (window & mask) == (pattern & mask)) begin
          m.pos  = seen - MATCH_W'(len) + MATCH_W'(1);
          m.last = 1'b0;
          pending.push_back(m);
          hits++;
        end
      end
      if (hits > 0) pending[pending.size()-1].last = 1'b1;
    endfunction

    function void check_match(match_pos_t pos, logic last);
      match_t m;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("unexpected match: pos=%0d last=%0b", pos, last);
      end else begin
        m = pending.pop_front();
        if (pos !== m.pos || last !== m.last) begin
          errors++;
          if (errors <= MAX_REPORTS)
            $display("match mismatch: expected pos=%0d last=%0b, got pos=%0d last=%0b",
                     m.pos, m.last, pos, last);
        end
      end
    endfunction
  endclass

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [PATTERN_W-1:0] cfg_data;
  logic                 in_valid;
  logic                 in_ready;
  logic [DATA_W-1:0]    in_data_bits;
  logic [COUNT_W-1:0]   in_bit_count;
  logic                 in_stream_start;
  logic                 out_valid;
  logic                 out_ready;
  logic [MATCH_W-1:0]   out_match_position;
  logic                 out_last_match;

  match_scoreboard sb = new();
  int  tx_idle_pct;
  int  rx_stall_pct;
  int  hold_left;
  bit  bit_backlog[$];

  bit_pattern_finder #(
    .PATTERN_MAX  (PATTERN_MAX),
    .POSITION_BITS(POSITION_BITS),
    .BITS_PER_ITEM(BITS_PER_ITEM)
  ) DUT (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_data_bits      (in_data_bits),
    .in_bit_count      (in_bit_count),
    .in_stream_start   (in_stream_start),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_match_position(out_match_position),
    .out_last_match    (out_last_match)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    out_ready = 1'b1;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        out_ready = 1'b0;
        hold_left--;
      end else begin
        out_ready = !($urandom_range(0, 99) < rx_stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) sb.check_match(out_match_position, out_last_match);
  end

  initial begin
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("Verification failed");
    $finish;
  end

  task automatic send_beat(logic [DATA_W-1:0] d, logic [COUNT_W-1:0] c, logic s);
    @(negedge clk);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid        = 1'b1;
    in_data_bits    = d;
    in_bit_count    = c;
    in_stream_start = s;
    do @(posedge clk); while (!in_ready);
    sb.take_beat(d, c, s);
  endtask

  // drop valid, drain every pending match, then let in-flight beats settle
  task automatic wait_quiet();
    @(negedge clk);
    in_valid = 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [PATTERN_W-1:0] value);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = value;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(idx, value);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic configure(logic [PATTERN_W-1:0] pattern, logic [LEN_W-1:0] len,
                           int tx_pct, int rx_pct);
    wait_quiet();
    write_reg(CFG_PATTERN_BITS, pattern);
    write_reg(CFG_PATTERN_LENGTH, PATTERN_W'(len));
    @(posedge clk);
    tx_idle_pct  = tx_pct;
    rx_stall_pct = rx_pct;
  endtask

  // mostly planted copies of the pattern between random runs of bits
  task automatic random_beats(int n_beats);
    logic [DATA_W-1:0]  d;
    logic [COUNT_W-1:0] c;
    logic               s;
    int                 len;
    int                 take;
    int                 k;
    int                 r;
    bit_backlog.delete();
    repeat (n_beats) begin
      len = sb.active_len();
      while (bit_backlog.size() < BITS_PER_ITEM) begin
        if (len > 0 && $urandom_range(0, 9) < 6) begin
          for (k = len - 1; k >= 0; k--) bit_backlog.push_back(sb.pattern[k]);
        end else begin
          repeat ($urandom_range(1, 16)) bit_backlog.push_back(bit'($urandom_range(0, 1)));
        end
      end
      r = $urandom_range(0, 15);
      if (r == 0) c = '0;
      else if (r == 1) c = COUNT_W'($urandom_range(9, 15));
      else c = COUNT_W'($urandom_range(1, BITS_PER_ITEM));
      take = (c > BITS_PER_ITEM) ? BITS_PER_ITEM : int'(c);
      d = DATA_W'($urandom());
      for (k = 0; k < take; k++) d[DATA_W-1-k] = bit_backlog.pop_front();
      s = ($urandom_range(0, 24) == 0);
      send_beat(d, c, s);
    end
  endtask

  initial begin
    int i;
    rst_n           = 1'b0;
    cfg_valid       = 1'b0;
    cfg_index       = '0;
    cfg_data        = '0;
    in_valid        = 1'b0;
    in_data_bits    = '0;
    in_bit_count    = '0;
    in_stream_start = 1'b0;
    tx_idle_pct     = 0;
    rx_stall_pct    = 0;
    hold_left       = 0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    send_beat(8'hFF, 4'd8, 1'b1);

    configure(64'h1, 7'd1, 0, 0);
    send_beat(8'hFF, 4'd8, 1'b0);
    send_beat(8'hA5, 4'd15, 1'b0);
    send_beat(8'h00, 4'd0, 1'b1);
    send_beat(8'h80, 4'd1, 1'b0);
    wait_quiet();
    write_reg(CFG_SPARE_LO, {$urandom(), $urandom()});
    write_reg(CFG_SPARE_HI, {$urandom(), $urandom()});

    configure('1, 7'd127, 0, 0);
    for (i = 0; i < 9; i++) send_beat(8'hFF, 4'd8, i == 0);

    configure('0, 7'd64, 0, 0);
    for (i = 0; i < 9; i++) send_beat(8'h00, 4'd8, i == 0);

    // hold the receiver off so the merge buffer fills and stalls the input
    configure(64'h1, 7'd1, 0, 0);
    hold_left = HOLD_CYCLES;
    for (i = 0; i < 12; i++) send_beat(8'hFF, 4'd8, 1'b0);

    configure({$urandom(), $urandom()}, LEN_W'($urandom_range(1, 4)), 0, 0);
    random_beats(PHASE_BEATS);
    configure({$urandom(), $urandom()}, 7'd8, 79, 0);
    random_beats(PHASE_BEATS);
    configure({$urandom(), $urandom()}, 7'd64, 0, 79);
    random_beats(PHASE_BEATS);
    configure('1, 7'd100, 38, 38);
    random_beats(PHASE_BEATS);
    configure({$urandom(), $urandom()}, 7'd0, 0, 0);
    random_beats(PHASE_BEATS);
    configure({$urandom(), $urandom()}, LEN_W'($urandom_range(1, 16)), 79, 0);
    random_beats(PHASE_BEATS);
    configure({$urandom(), $urandom()}, LEN_W'($urandom_range(17, 63)), 0, 79);
    random_beats(PHASE_BEATS);
    configure('0, 7'd1, 38, 38);
    random_beats(PHASE_BEATS);

    wait_quiet();
    if (sb.errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
